### rtl/fvg_pkg.sv
package fvg_pkg;

  localparam int unsigned RdsW = 22;
  localparam int unsigned FdsW = 40;
  localparam int unsigned SubW = 32;
  localparam logic [31:0] Fat12Limit = 32'd4085;
  localparam logic [31:0] Fat16Limit = 32'd65525;

  typedef enum logic [1:0] {
    KIND_FAT12 = 2'd0,
    KIND_FAT16 = 2'd1,
    KIND_FAT32 = 2'd2
  } fat_kind_t;

  typedef struct packed {
    logic [15:0] bytes_per_sector;
    logic [7:0]  sectors_per_cluster;
    logic [15:0] reserved_sectors;
    logic [7:0]  fat_copies;
    logic [15:0] root_entry_count;
    logic [15:0] total_sectors_small;
    logic [31:0] total_sectors_large;
    logic [15:0] fat_size_small;
    logic [31:0] fat_size_large;
  } geo_in_t;

  typedef struct packed {
    logic [1:0]  fat_kind;
    logic [21:0] root_dir_sectors;
    logic [31:0] fat_size_used;
    logic [39:0] first_data_sector;
    logic [31:0] cluster_count;
    logic        geometry_error;
  } geo_out_t;

endpackage

### rtl/fvg_if.sv
interface fvg_in_if;
  logic valid;
  logic ready;
  fvg_pkg::geo_in_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface fvg_out_if;
  logic valid;
  logic ready;
  fvg_pkg::geo_out_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### rtl/fvg_div_cell.sv
module fvg_div_cell #(
  parameter int unsigned W = 22,
  parameter int unsigned DW = 16,
  parameter int unsigned BIT = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [W-1:0]  num_i,
  input  logic [W-1:0]  quo_i,
  input  logic [W-1:0]  rem_i,
  input  logic [DW-1:0] div_i,
  output logic [W-1:0]  num_o,
  output logic [W-1:0]  quo_o,
  output logic [W-1:0]  rem_o,
  output logic [DW-1:0] div_o
);

  logic [W:0] sh;
  logic [W:0] df;
  logic       ge;
  logic [W-1:0] num_r, quo_r, rem_r;
  logic [DW-1:0] div_r;

  always_comb begin
    sh = {rem_i, num_i[BIT]};
    df = sh - (W+1)'(div_i);
    ge = sh >= (W+1)'(div_i);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= num_i;
      div_r <= div_i;
      rem_r <= ge ? df[W-1:0] : sh[W-1:0];
      quo_r <= quo_i | (ge ? (W'(1) << BIT) : '0);
    end
  end

  assign num_o = num_r;
  assign quo_o = quo_r;
  assign rem_o = rem_r;
  assign div_o = div_r;

endmodule

### rtl/fvg_div_chain.sv
module fvg_div_chain #(
  parameter int unsigned W = 22,
  parameter int unsigned DW = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [W-1:0]  num_i,
  input  logic [DW-1:0] div_i,
  output logic [W-1:0]  quo_o
);

  logic [W-1:0]  num_s [W+1];
  logic [W-1:0]  quo_s [W+1];
  logic [W-1:0]  rem_s [W+1];
  logic [DW-1:0] div_s [W+1];

  assign num_s[0] = num_i;
  assign quo_s[0] = '0;
  assign rem_s[0] = '0;
  assign div_s[0] = div_i;

  for (genvar i = 0; i < W; i++) begin : g_cell
    fvg_div_cell #(.W(W), .DW(DW), .BIT(W-1-i)) u_cell (
      .clk(clk), .en(en),
      .num_i(num_s[i]), .quo_i(quo_s[i]), .rem_i(rem_s[i]), .div_i(div_s[i]),
      .num_o(num_s[i+1]), .quo_o(quo_s[i+1]), .rem_o(rem_s[i+1]),
      .div_o(div_s[i+1])
    );
  end

  assign quo_o = quo_s[W];

endmodule

### rtl/fvg_delay.sv
module fvg_delay #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_r [D];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d_i;
      for (int i = 1; i < D; i++) tap_r[i] <= tap_r[i-1];
    end
  end

  assign q_o = tap_r[D-1];

endmodule

### rtl/fat_volume_geometry.sv
// FAT volume geometry and type determination.
// in_ channel: one item holds the boot-sector geometry fields of one volume.
// out_ channel: one item per input item, in order, with root directory
// sectors, the FAT size in use, the first data sector, the cluster count,
// the FAT type and an error flag for a zero sector or cluster size.
// The block is a pipeline of restoring divider cells: 22 cells for the root
// directory division, one stage that forms the first data sector and the
// data sector count, 32 cells for the cluster division and one stage that
// classifies the count. Throughput is one item per cycle while the receiver
// keeps taking results. The whole pipe advances whenever its last stage is
// empty or the receiver takes the result, so a stalled receiver holds every
// stage and in_ready falls with it.
// Synchronous reset empties the pipe; no item is lost or shown twice.
module fat_volume_geometry (
  input  logic       clk,
  input  logic       rst_n,
  fvg_in_if.sink     in_ch,
  fvg_out_if.source  out_ch
);

  localparam int unsigned Lat = fvg_pkg::RdsW + fvg_pkg::SubW + 2;

  logic       adv;
  logic [Lat-1:0] vld_r;
  fvg_pkg::geo_in_t a;

  assign adv = !vld_r[Lat-1] || out_ch.ready;
  assign in_ch.ready = adv;
  assign a = in_ch.data;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[Lat-2:0], in_ch.valid};
  end

  logic [fvg_pkg::RdsW-1:0] rnum;
  logic [15:0] bps_m1;
  logic [fvg_pkg::RdsW-1:0] rq;
  assign bps_m1 = a.bytes_per_sector - 16'd1;
  assign rnum = {1'b0, a.root_entry_count, 5'd0} + {6'd0, bps_m1};

  fvg_div_chain #(.W(fvg_pkg::RdsW), .DW(16)) u_rdiv (
    .clk(clk), .en(adv), .num_i(rnum), .div_i(a.bytes_per_sector), .quo_o(rq)
  );

  logic [31:0] fsz, tot;
  logic        err;
  assign fsz = (a.fat_size_small != 16'd0) ? {16'd0, a.fat_size_small} : a.fat_size_large;
  assign tot = (a.total_sectors_small != 16'd0) ? {16'd0, a.total_sectors_small}
                                               : a.total_sectors_large;
  assign err = (a.bytes_per_sector == 16'd0) || (a.sectors_per_cluster == 8'd0);

  localparam int unsigned SW = 32 + 32 + 16 + 8 + 8 + 1 + 1;
  logic [SW-1:0] side_d, side_q;
  assign side_d = {fsz, tot, a.reserved_sectors, a.fat_copies, a.sectors_per_cluster,
                   err, (a.bytes_per_sector == 16'd0)};

  fvg_delay #(.W(SW), .D(fvg_pkg::RdsW)) u_side (
    .clk(clk), .en(adv), .d_i(side_d), .q_o(side_q)
  );

  logic [31:0] s_fsz, s_tot;
  logic [15:0] s_rsv;
  logic [7:0]  s_cp, s_spc;
  logic        s_err, s_bz;
  logic [fvg_pkg::RdsW-1:0] rds;
  logic [fvg_pkg::FdsW-1:0] fprod;
  logic [fvg_pkg::FdsW-1:0] first;
  logic [fvg_pkg::FdsW:0]   diff;
  logic        ok;
  assign {s_fsz, s_tot, s_rsv, s_cp, s_spc, s_err, s_bz} = side_q;
  assign rds = s_bz ? '0 : rq;
  assign fprod = s_cp * s_fsz;
  assign first = fprod + fvg_pkg::FdsW'(s_rsv) + fvg_pkg::FdsW'(rds);
  assign diff = {9'd0, s_tot} - {1'b0, first};
  assign ok = !s_err && !diff[fvg_pkg::FdsW];

  logic [31:0] cnum_r;
  logic [7:0]  spc_r;
  localparam int unsigned MW = fvg_pkg::RdsW + 32 + fvg_pkg::FdsW + 1;
  logic [MW-1:0] mid_r, mid_q;
  always_ff @(posedge clk) begin
    if (adv) begin
      cnum_r <= ok ? diff[31:0] : '0;
      spc_r  <= (s_spc == 8'd0) ? 8'd1 : s_spc;
      mid_r  <= {rds, s_fsz, first, s_err};
    end
  end

  logic [31:0] cq;
  fvg_div_chain #(.W(fvg_pkg::SubW), .DW(8)) u_cdiv (
    .clk(clk), .en(adv), .num_i(cnum_r), .div_i(spc_r), .quo_o(cq)
  );

  fvg_delay #(.W(MW), .D(fvg_pkg::SubW)) u_mid (
    .clk(clk), .en(adv), .d_i(mid_r), .q_o(mid_q)
  );

  fvg_pkg::geo_out_t res_r;
  fvg_pkg::fat_kind_t kind;
  always_comb begin
    if (cq < fvg_pkg::Fat12Limit) kind = fvg_pkg::KIND_FAT12;
    else if (cq < fvg_pkg::Fat16Limit) kind = fvg_pkg::KIND_FAT16;
    else kind = fvg_pkg::KIND_FAT32;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r.fat_kind <= kind;
      {res_r.root_dir_sectors, res_r.fat_size_used, res_r.first_data_sector,
       res_r.geometry_error} <= mid_q;
      res_r.cluster_count <= cq;
    end
  end

  assign out_ch.valid = vld_r[Lat-1];
  assign out_ch.data = res_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed under stall");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.geometry_error |-> out_ch.data.cluster_count == 32'd0)
    else $error("cluster count with geometry error");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output");

endmodule

### tb/sv/geometry_check.sv
`timescale 1ns / 1ps

class geometry_check;
  fvg_pkg::geo_out_t pending_q[$];
  int errors;

  function fvg_pkg::geo_out_t predict(fvg_pkg::geo_in_t g);
    fvg_pkg::geo_out_t r;
    logic [63:0] rds;
    logic [63:0] fsz;
    logic [63:0] total;
    logic [63:0] first;
    logic [63:0] clusters;
    logic bad;
    bad = (g.bytes_per_sector == 0) || (g.sectors_per_cluster == 0);
    rds = 0;
    clusters = 0;
    if (g.bytes_per_sector != 0) begin
      rds = (64'(g.root_entry_count) * 32 + 64'(g.bytes_per_sector) - 1)
            / 64'(g.bytes_per_sector);
    end
    fsz = (g.fat_size_small != 0) ? 64'(g.fat_size_small) : 64'(g.fat_size_large);
    total = (g.total_sectors_small != 0) ? 64'(g.total_sectors_small)
                                         : 64'(g.total_sectors_large);
    first = 64'(g.reserved_sectors) + 64'(g.fat_copies) * fsz + rds;
    if (!bad && total >= first) begin
      clusters = (total - first) / 64'(g.sectors_per_cluster);
    end
    if (clusters < 4085) r.fat_kind = fvg_pkg::KIND_FAT12;
    else if (clusters < 65525) r.fat_kind = fvg_pkg::KIND_FAT16;
    else r.fat_kind = fvg_pkg::KIND_FAT32;
    r.root_dir_sectors = rds[21:0];
    r.fat_size_used = fsz[31:0];
    r.first_data_sector = first[39:0];
    r.cluster_count = clusters[31:0];
    r.geometry_error = bad;
    return r;
  endfunction

  function void note_volume(fvg_pkg::geo_in_t g);
    pending_q.push_back(predict(g));
  endfunction

  task report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  task check_result(fvg_pkg::geo_out_t r);
    fvg_pkg::geo_out_t e;
    if (pending_q.size() == 0) begin
      report("unexpected result", 64'(r), 64'd0);
      return;
    end
    e = pending_q.pop_front();
    if (r.fat_kind !== e.fat_kind) report("fat_kind", 64'(r.fat_kind), 64'(e.fat_kind));
    if (r.root_dir_sectors !== e.root_dir_sectors)
      report("root_dir_sectors", 64'(r.root_dir_sectors), 64'(e.root_dir_sectors));
    if (r.fat_size_used !== e.fat_size_used)
      report("fat_size_used", 64'(r.fat_size_used), 64'(e.fat_size_used));
    if (r.first_data_sector !== e.first_data_sector)
      report("first_data_sector", 64'(r.first_data_sector), 64'(e.first_data_sector));
    if (r.cluster_count !== e.cluster_count)
      report("cluster_count", 64'(r.cluster_count), 64'(e.cluster_count));
    if (r.geometry_error !== e.geometry_error)
      report("geometry_error", 64'(r.geometry_error), 64'(e.geometry_error));
  endtask
endclass

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  logic clk;
  logic rst_n;
  int cycles;
  int out_wait;
  bit sending_done;
  geometry_check volumes;

  fvg_in_if in_ch();
  fvg_out_if out_ch();

  fat_volume_geometry dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function fvg_pkg::geo_in_t random_volume();
    fvg_pkg::geo_in_t g;
    g = fvg_pkg::geo_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    case ($urandom_range(0, 5))
      0: ;
      1: begin
        g.bytes_per_sector = 16'd512 << $urandom_range(0, 3);
        g.sectors_per_cluster = 8'd1 << $urandom_range(0, 7);
        g.reserved_sectors = 16'($urandom_range(1, 64));
        g.fat_copies = 8'($urandom_range(1, 2));
        g.root_entry_count = $urandom_range(0, 1) ? 16'd512 : 16'd0;
        g.total_sectors_small = $urandom_range(0, 1) ? 16'($urandom) : 16'd0;
        g.fat_size_small = $urandom_range(0, 1) ? 16'($urandom_range(1, 256)) : 16'd0;
        g.fat_size_large = $urandom_range(1, 1 << 16);
      end
      2: begin
        g.total_sectors_small = 16'd0;
        g.fat_size_small = 16'($urandom_range(0, 64));
        g.fat_size_large = $urandom_range(0, 1 << 20);
        g.fat_copies = 8'($urandom_range(0, 3));
        g.reserved_sectors = 16'($urandom_range(0, 4096));
      end
      3: begin
        g.bytes_per_sector = 16'($urandom_range(0, 3));
        g.sectors_per_cluster = 8'($urandom_range(0, 3));
      end
      default: begin
        g.sectors_per_cluster = 8'($urandom_range(1, 255));
        g.total_sectors_small = 16'd0;
        g.fat_size_small = 16'd0;
        g.fat_copies = 8'($urandom_range(1, 2));
        g.fat_size_large = $urandom_range(0, 1 << 16);
      end
    endcase
    return g;
  endfunction

  task send_volume(fvg_pkg::geo_in_t g);
    int idle;
    idle = $urandom_range(0, 14);
    if (idle > 0) begin
      in_ch.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= g;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    volumes.note_volume(g);
  endtask

  task send_directed();
    fvg_pkg::geo_in_t g;
    g = '0;
    send_volume(g);
    send_volume('1);
    g = '{16'd512, 8'd1, 16'd1, 8'd2, 16'd224, 16'd2880, 32'd0, 16'd9, 32'd0};
    send_volume(g);
    g = '{16'd512, 8'd4, 16'd4, 8'd2, 16'd512, 16'd0, 32'd204800, 16'd200, 32'd0};
    send_volume(g);
    g = '{16'd512, 8'd8, 16'd32, 8'd2, 16'd0, 16'd0, 32'd4194304, 16'd0, 32'd4096};
    send_volume(g);
    g = '{16'd512, 8'd1, 16'd1, 8'd1, 16'd0, 16'd0, 32'd4086, 16'd0, 32'd0};
    send_volume(g);
    g.total_sectors_large = 32'd4085;
    send_volume(g);
    g.total_sectors_large = 32'd65526;
    send_volume(g);
    g.total_sectors_large = 32'd65525;
    send_volume(g);
    g.total_sectors_large = 32'd0;
    send_volume(g);
    g = '{16'd0, 8'd4, 16'd4, 8'd2, 16'd512, 16'd60000, 32'd0, 16'd10, 32'd0};
    send_volume(g);
    g = '{16'd512, 8'd0, 16'd4, 8'd2, 16'd512, 16'd60000, 32'd0, 16'd10, 32'd0};
    send_volume(g);
    g = '{16'd1, 8'd255, 16'hFFFF, 8'hFF, 16'hFFFF, 16'd0, 32'hFFFFFFFF, 16'd0,
          32'hFFFFFFFF};
    send_volume(g);
    g = '{16'd1, 8'd1, 16'd0, 8'd0, 16'd0, 16'd0, 32'hFFFFFFFF, 16'd0, 32'd0};
    send_volume(g);
  endtask

  always @(posedge clk) begin : p_sink
    int w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_wait <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        volumes.check_result(out_ch.data);
        w = $urandom_range(0, 14);
      end else begin
        w = (out_wait > 0) ? out_wait - 1 : 0;
      end
      out_wait <= w;
      out_ch.ready <= (w == 0);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    volumes = new();
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_directed();
    for (int i = 0; i < 1000; i++) begin
      if (i % 200 < 40) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= random_volume();
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        volumes.note_volume(in_ch.data);
      end else begin
        send_volume(random_volume());
      end
    end
    in_ch.valid <= 1'b0;
    while (volumes.pending_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (volumes.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
